### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 decode block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that implies a consequence on the next clock edge
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/udh_pkg.sv
// Package of the UTF-8 decode block: command codes, event type, state enum
// and the Unicode block bound ROM. No dependencies.
package udh_pkg;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned ROM_SIZE = 166;
  localparam logic [20:0] CP_TOP   = 21'h1fffff;

  typedef enum logic [1:0] {EV_DATA, EV_READ, EV_CLEAR} ev_kind_e;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_READ, ST_UPD} udh_state_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [20:0] cp;
    logic        valid;
    logic [2:0]  bytes;
    logic [7:0]  idx;
    logic        last;
  } udh_ev_t;

  localparam logic [20:0] BOUND_ROM [ROM_SIZE] = '{
    21'h0, 21'h1f, 21'h7f, 21'hff, 21'h17f, 21'h24f, 21'h2af, 21'h2ff, 21'h36f, 21'h3ff,
    21'h4ff, 21'h52f, 21'h58f, 21'h5ff, 21'h6ff, 21'h74f, 21'h77f, 21'h7bf, 21'h7ff,
    21'h83f, 21'h85f, 21'h89f, 21'h8ff, 21'h97f, 21'h9ff, 21'ha7f, 21'haff, 21'hb7f,
    21'hbff, 21'hc7f, 21'hcff, 21'hd7f, 21'hdff, 21'he7f, 21'heff, 21'hfff, 21'h109f,
    21'h10ff, 21'h11ff, 21'h137f, 21'h139f, 21'h13ff, 21'h167f, 21'h169f, 21'h16ff,
    21'h171f, 21'h173f, 21'h175f, 21'h177f, 21'h17ff, 21'h18af, 21'h18ff, 21'h194f,
    21'h197f, 21'h19df, 21'h19ff, 21'h1a1f, 21'h1aaf, 21'h1aff, 21'h1b7f, 21'h1bbf,
    21'h1bff, 21'h1c4f, 21'h1c7f, 21'h1cbf, 21'h1ccf, 21'h1cff, 21'h1d7f, 21'h1dbf,
    21'h1dff, 21'h1eff, 21'h1fff, 21'h206f, 21'h209f, 21'h20cf, 21'h20ff, 21'h214f,
    21'h218f, 21'h21ff, 21'h22ff, 21'h23ff, 21'h243f, 21'h245f, 21'h24ff, 21'h257f,
    21'h259f, 21'h25ff, 21'h26ff, 21'h27bf, 21'h27ef, 21'h27ff, 21'h28ff, 21'h297f,
    21'h29ff, 21'h2aff, 21'h2bff, 21'h2c5f, 21'h2c7f, 21'h2cff, 21'h2d2f, 21'h2d7f,
    21'h2ddf, 21'h2dff, 21'h2e7f, 21'h2eff, 21'h2fdf, 21'h2fef, 21'h2fff, 21'h303f,
    21'h309f, 21'h30ff, 21'h312f, 21'h318f, 21'h319f, 21'h31bf, 21'h31ef, 21'h31ff,
    21'h32ff, 21'h33ff, 21'h4dbf, 21'h4dff, 21'h9fff, 21'ha48f, 21'ha4cf, 21'ha4ff,
    21'ha63f, 21'ha69f, 21'ha6ff, 21'ha71f, 21'ha7ff, 21'ha82f, 21'ha83f, 21'ha87f,
    21'ha8df, 21'ha8ff, 21'ha92f, 21'ha95f, 21'ha97f, 21'ha9df, 21'ha9ff, 21'haa5f,
    21'haa7f, 21'haadf, 21'haaff, 21'hab2f, 21'hab6f, 21'habbf, 21'habff, 21'hd7af,
    21'hd7ff, 21'hdb7f, 21'hdbff, 21'hdfff, 21'hf8ff, 21'hfaff, 21'hfb4f, 21'hfdff,
    21'hfe0f, 21'hfe1f, 21'hfe2f, 21'hfe4f, 21'hfe6f, 21'hfeff, 21'hffef, 21'hffff,
    21'h10ffff
  };

  // Bound of one bin; entries past the ROM read as the top of the code space
  function automatic logic [20:0] udh_bound(input logic [7:0] idx);
    logic [20:0] res;
    res = CP_TOP;
    if (32'(idx) < ROM_SIZE) begin
      res = BOUND_ROM[idx];
    end
    return res;
  endfunction

endpackage

### hw/rtl/udh_if.sv
// Channel interfaces of the UTF-8 decode block: input item and result item.
// Depends on nothing but the port widths of the block.
interface udh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       last_of_word;
  logic [7:0] counter_index;

  modport source (output valid, cmd, data_byte, last_of_word, counter_index, input ready);
  modport sink   (input valid, cmd, data_byte, last_of_word, counter_index, output ready);
endinterface

interface udh_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_valid;
  logic [7:0]  block_index;
  logic [2:0]  byte_count;
  logic [31:0] count_value;
  logic        last_result;

  modport source (output valid, code_point, is_valid, block_index, byte_count, count_value,
                  last_result, input ready);
  modport sink   (input valid, code_point, is_valid, block_index, byte_count, count_value,
                  last_result, output ready);
endinterface

### hw/rtl/udh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module udh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 166
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/udh_fifo.sv
// Event queue between the decode front and the counter back end.
// Depends on udh_pkg for the event type and depth.
`include "assert_macros.svh"
module udh_fifo
  import udh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  udh_ev_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output udh_ev_t rdata_o,
  output logic    empty_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  udh_ev_t       buf_q [QDEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = buf_q[rp_q];

  // Advance pointers and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed event
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= wdata_i;
    end
  end

  `ASSERT_ALWAYS(a_fifo_no_ovf, !(push_i && full_o), "event pushed into full queue")
  `ASSERT_ALWAYS(a_fifo_no_udf, !(pop_i && empty_o), "event popped from empty queue")

endmodule

### hw/rtl/udh_front.sv
// Decode front: accepts input items, runs the UTF-8 sequence state and
// expands each item into up to four events. Depends on udh_pkg, udh_if.
`include "assert_macros.svh"
module udh_front
  import udh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  udh_in_if.sink  in_i,
  output logic    push_o,
  output udh_ev_t ev_o,
  input  logic    full_i
);

  logic [23:0] pb_q, pb_d;
  logic [1:0]  pc_q, pc_d;
  udh_ev_t     ev_q [4];
  udh_ev_t     evs  [4];
  logic [2:0]  rem_q, rem_d, n;
  logic [1:0]  rd_q, rd_d;
  logic        accept;
  logic        start;
  logic        ok;
  logic [7:0]  lead, b;
  logic [2:0]  need;

  function automatic udh_ev_t mk_ev(input ev_kind_e kind, input logic [20:0] cp,
                                    input logic valid, input logic [2:0] bytes,
                                    input logic [7:0] idx);
    udh_ev_t e;
    e.kind  = kind;
    e.cp    = cp;
    e.valid = valid;
    e.bytes = bytes;
    e.idx   = idx;
    e.last  = 1'b0;
    return e;
  endfunction

  assign push_o     = (rem_q != '0) && !full_i;
  assign ev_o       = ev_q[rd_q];
  assign in_i.ready = (rem_q == '0) || ((rem_q == 3'd1) && push_o);
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign lead       = pb_q[7:0];

  // Expand the item into events and next sequence state
  always_comb begin
    evs   = '{default: '0};
    n     = '0;
    pb_d  = pb_q;
    pc_d  = pc_q;
    start = 1'b0;
    ok    = 1'b0;
    need  = (lead < 8'he0) ? 3'd2 : ((lead < 8'hf0) ? 3'd3 : 3'd4);
    case (in_i.cmd)
      CMD_DATA: begin
        if (pc_q == '0) begin
          start = 1'b1;
        end else begin
          ok = (b & 8'hc0) == 8'h80;
          if (pc_q == 2'd1) begin
            if (lead == 8'he0 && b < 8'ha0) ok = 1'b0;
            if (lead == 8'hf0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hf4 && b >= 8'h90) ok = 1'b0;
          end
          if (!ok) begin
            // Broken sequence: drop buffered bytes as invalid, restart on b
            for (int k = 0; k < 3; k++) begin
              if (2'(k) < pc_q) begin
                evs[n[1:0]] = mk_ev(EV_DATA, {13'h0, pb_q[8*k +: 8]}, 1'b0, 3'd1, 8'h0);
                n = n + 3'd1;
              end
            end
            pb_d  = '0;
            pc_d  = '0;
            start = 1'b1;
          end else if ((3'(pc_q) + 3'd1) < need) begin
            pb_d[8*pc_q +: 8] = b;
            pc_d = pc_q + 2'd1;
          end else begin
            case (need)
              3'd2: evs[n[1:0]] = mk_ev(EV_DATA, {10'h0, lead[4:0], b[5:0]}, 1'b1,
                                        3'd2, 8'h0);
              3'd3: evs[n[1:0]] = mk_ev(EV_DATA, {5'h0, lead[3:0], pb_q[13:8], b[5:0]},
                                        1'b1, 3'd3, 8'h0);
              default: evs[n[1:0]] = mk_ev(EV_DATA,
                                           {lead[2:0], pb_q[13:8], pb_q[21:16], b[5:0]},
                                           1'b1, 3'd4, 8'h0);
            endcase
            n    = n + 3'd1;
            pb_d = '0;
            pc_d = '0;
          end
        end
        if (start) begin
          if (b < 8'h80) begin
            evs[n[1:0]] = mk_ev(EV_DATA, {13'h0, b}, 1'b1, 3'd1, 8'h0);
            n = n + 3'd1;
          end else if (b < 8'hc2 || b > 8'hf4) begin
            evs[n[1:0]] = mk_ev(EV_DATA, {13'h0, b}, 1'b0, 3'd1, 8'h0);
            n = n + 3'd1;
          end else begin
            pb_d = {16'h0, b};
            pc_d = 2'd1;
          end
        end
        // Word ends with a sequence open: flush it as invalid bytes
        if (in_i.last_of_word && pc_d != '0) begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < pc_d) begin
              evs[n[1:0]] = mk_ev(EV_DATA, {13'h0, pb_d[8*k +: 8]}, 1'b0, 3'd1, 8'h0);
              n = n + 3'd1;
            end
          end
          pb_d = '0;
          pc_d = '0;
        end
        if (n != '0) begin
          evs[n[1:0] - 2'd1].last = 1'b1;
        end
      end
      CMD_READ: begin
        evs[0]      = mk_ev(EV_READ, '0, 1'b0, 3'd0, in_i.counter_index);
        evs[0].last = 1'b1;
        n           = 3'd1;
      end
      CMD_CLEAR: begin
        evs[0] = mk_ev(EV_CLEAR, '0, 1'b0, 3'd0, 8'h0);
        n      = 3'd1;
      end
      default: begin
        n = '0;
      end
    endcase
  end

  // Load the event buffer on accept, else drain one per cycle while the queue is not full
  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (accept) begin
      rem_d = n;
      rd_d  = '0;
    end else if (push_o) begin
      rem_d = rem_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q  <= '0;
      pc_q  <= '0;
      rem_q <= '0;
      rd_q  <= '0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
      if (accept) begin
        pb_q <= pb_d;
        pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q <= evs;
    end
  end

  `ASSERT_ALWAYS(a_rem_bound, rem_q <= 3'd4, "event buffer holds more than four events")

endmodule

### hw/rtl/udh_back.sv
// Counter back end: bins each valid character by a search over the bound ROM, updates
// the saturating counters in RAM and registers the result item.
// Depends on udh_pkg, udh_if, udh_ram.
`include "assert_macros.svh"
module udh_back
  import udh_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = 166,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  udh_ev_t  ev_i,
  output logic     pop_o,
  udh_out_if.source out_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);

  udh_state_e             state_q, state_d;
  udh_ev_t                ev_q, ev_d;
  logic [7:0]             pos_q, pos_d, cand;
  logic [2:0]             step_q, step_d;
  logic [7:0]             bin_q, bin_d;
  logic [8:0]             bin9;
  logic                   inr_q, inr_d;
  logic [NUM_BLOCKS-1:0]  vld_q, vld_d;
  logic                   re, we;
  logic [COUNT_WIDTH-1:0] rdata, cnt, wdata;
  logic [63:0]            cnt_ext;
  logic                   ovld_q, ovld_d, oload;
  logic [20:0]            ocp_q;
  logic                   oval_q;
  logic [7:0]             obin_q;
  logic [2:0]             obyt_q;
  logic [31:0]            ocnt_q;
  logic                   olast_q;

  udh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (bin_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (bin_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign cand    = pos_q | (8'd1 << step_q);
  assign bin9    = {1'b0, pos_d} + 9'd1;
  assign cnt     = (inr_q && vld_q[bin_q[AW-1:0]]) ? rdata : '0;
  assign wdata   = (&cnt) ? cnt : cnt + 1'b1;
  assign cnt_ext = 64'(cnt);
  assign pop_o   = (state_q == ST_IDLE) && !empty_i;

  // Sequence one event: pop, search bin, read counter, update and emit
  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    pos_d   = pos_q;
    step_d  = step_q;
    bin_d   = bin_q;
    inr_d   = inr_q;
    vld_d   = vld_q;
    re      = 1'b0;
    we      = 1'b0;
    oload   = 1'b0;
    ovld_d  = ovld_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          ev_d = ev_i;
          case (ev_i.kind)
            EV_DATA: begin
              inr_d = 1'b1;
              bin_d = '0;
              pos_d = '0;
              step_d = 3'd7;
              state_d = ev_i.valid ? ST_SEARCH : ST_READ;
            end
            EV_READ: begin
              inr_d   = {1'b0, ev_i.idx} < 9'(NUM_BLOCKS);
              bin_d   = ev_i.idx;
              state_d = ST_READ;
            end
            default: begin
              vld_d = '0;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (udh_bound(cand) < ev_q.cp) begin
          pos_d = cand;
        end
        step_d = step_q - 3'd1;
        if (step_q == '0) begin
          bin_d   = (bin9 >= 9'(NUM_BLOCKS)) ? 8'(NUM_BLOCKS - 1) : bin9[7:0];
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        re      = inr_q;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!ovld_q || out_o.ready) begin
          oload   = 1'b1;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
          if (ev_q.kind == EV_DATA) begin
            we = 1'b1;
            vld_d[bin_q[AW-1:0]] = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      ovld_q  <= ovld_d;
    end
  end

  // Hold event payload and the output register
  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    bin_q  <= bin_d;
    inr_q  <= inr_d;
    if (oload) begin
      ocp_q   <= ev_q.cp;
      oval_q  <= ev_q.valid;
      obin_q  <= bin_q;
      obyt_q  <= ev_q.bytes;
      ocnt_q  <= (ev_q.kind == EV_READ) ? cnt_ext[31:0] : 32'd0;
      olast_q <= ev_q.last;
    end
  end

  assign out_o.valid       = ovld_q;
  assign out_o.code_point  = ocp_q;
  assign out_o.is_valid    = oval_q;
  assign out_o.block_index = obin_q;
  assign out_o.byte_count  = obyt_q;
  assign out_o.count_value = ocnt_q;
  assign out_o.last_result = olast_q;

  `ASSERT_NEXT(a_search_ends, state_q == ST_SEARCH && step_q == '0, state_q == ST_READ,
               "bin search did not finish after eight steps")
  `ASSERT_ALWAYS(a_no_overwrite, !(oload && ovld_q && !out_o.ready),
                 "result register overwritten while held")

endmodule

### hw/rtl/utf8_decode_block_histogram_core.sv
// UTF-8 decoder with Unicode block histogram, top level.
// Channels: in_i takes items (cmd, data_byte, last_of_word, counter_index),
// out_o gives result items (code_point, is_valid, block_index, byte_count,
// count_value, last_result); both move an item when valid and ready are high.
// The front takes a new item once its event buffer is empty or is pushing its
// last event, and queues up to four events per item into a four-entry queue.
// The back end handles one event at a time: a valid character takes an
// 8-step search of the bound ROM, one counter RAM read and one update; an
// invalid byte or a read skips the search, and a clear only resets the
// counter valid bits.
// Sustained rate is set by the back end's search and RAM read-modify-write.
// Reset empties the queue, drops any open sequence and marks all counters
// zero through per-counter valid bits; a clear only marks the counters zero.
// When the receiver stalls, the result register holds, the back end waits,
// the queue fills and then in_i.ready falls.
module utf8_decode_block_histogram_core
  import udh_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = 166,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  udh_in_if.sink    in_i,
  udh_out_if.source out_o
);

  logic    push, full, pop, empty;
  udh_ev_t ev_w, ev_r;

  udh_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .ev_o   (ev_w),
    .full_i (full)
  );

  udh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (ev_w),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (ev_r),
    .empty_o (empty)
  );

  udh_back #(.NUM_BLOCKS(NUM_BLOCKS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ev_i    (ev_r),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### tb/tb_udh_pkg.sv
`timescale 1ns / 1ps
// Shared types for the UTF-8 decode block testbench: input and result items.
// Depends on udh_pkg for the command codes.
package tb_udh_pkg;
  import udh_pkg::*;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       last_of_word;
    logic [7:0] counter_index;
  } byte_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_valid;
    logic [7:0]  block_index;
    logic [2:0]  byte_count;
    logic [31:0] count_value;
    logic        last_result;
  } char_result_t;
endpackage

### tb/tb_udh_if.sv
`timescale 1ns / 1ps
// Interface used by the testbench to ask the receiver for a long stall.
// Depends on nothing; the block channels come from the RTL interfaces.
interface tb_stall_if;
  logic hold_off;
endinterface

### tb/tb_utf8_decode_block_histogram_core.sv
`timescale 1ns / 1ps
// Testbench of utf8_decode_block_histogram_core: directed and random byte
// streams and commands, checked against an in-bench decoder and histogram.
// Depends on udh_pkg, tb_udh_pkg, udh_if and tb_udh_if.
module tb_utf8_decode_block_histogram_core;
  import udh_pkg::*;
  import tb_udh_pkg::*;

  localparam int unsigned NBINS = 166;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  udh_in_if   in_ch ();
  udh_out_if  out_ch ();
  tb_stall_if stall ();

  utf8_decode_block_histogram_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state kept by the bench
  logic [23:0]  seq_bytes;
  int unsigned  seq_len;
  logic [31:0]  hist [NBINS];
  char_result_t expected_q [$];
  int unsigned  n_fail, n_sent, n_chars, n_bad;

  // Bin lookup: first bound at or above the code point
  function automatic logic [7:0] bin_of(input logic [20:0] cp);
    for (int n = 1; n < NBINS; n++) if (cp <= BOUND_ROM[n]) return 8'(n);
    return 8'(NBINS - 1);
  endfunction

  task automatic push_result(input logic [20:0] cp, input logic ok, input logic [7:0] bin,
                             input logic [2:0] nb);
    char_result_t r;
    r = '{code_point: cp, is_valid: ok, block_index: bin, byte_count: nb,
          count_value: 32'd0, last_result: 1'b0};
    if (hist[bin] != 32'hffff_ffff) hist[bin]++;
    if (ok) n_chars++; else n_bad++;
    expected_q.push_back(r);
  endtask

  task automatic flush_seq();
    for (int k = 0; k < seq_len; k++) push_result(21'(seq_bytes[8*k +: 8]), 1'b0, 8'd0, 3'd1);
    seq_bytes = '0;
    seq_len = 0;
  endtask

  task automatic open_byte(input logic [7:0] b);
    if (b < 8'h80) push_result(21'(b), 1'b1, bin_of(21'(b)), 3'd1);
    else if (b < 8'hc2 || b > 8'hf4) push_result(21'(b), 1'b0, 8'd0, 3'd1);
    else begin
      seq_bytes = {16'd0, b};
      seq_len = 1;
    end
  endtask

  // Work out the results of one accepted item
  task automatic predict_item(input byte_item_t it);
    int n_prior, need;
    logic [7:0] lead, b;
    logic ok;
    logic [20:0] cp;
    n_prior = expected_q.size();
    b = it.data_byte;
    if (it.cmd == CMD_DATA) begin
      if (seq_len == 0) open_byte(b);
      else begin
        lead = seq_bytes[7:0];
        need = lead < 8'he0 ? 2 : (lead < 8'hf0 ? 3 : 4);
        ok = (b & 8'hc0) == 8'h80;
        if (seq_len == 1) begin
          if (lead == 8'he0 && b < 8'ha0) ok = 1'b0;
          if (lead == 8'hf0 && b < 8'h90) ok = 1'b0;
          if (lead == 8'hf4 && b >= 8'h90) ok = 1'b0;
        end
        if (!ok) begin
          flush_seq();
          open_byte(b);
        end else if (seq_len + 1 < need) begin
          seq_bytes[8*seq_len +: 8] = b;
          seq_len++;
        end else begin
          cp = 21'(lead & (8'hff >> need));
          for (int k = 1; k < need - 1; k++) cp = (cp << 6) | 21'(seq_bytes[8*k +: 6]);
          cp = (cp << 6) | 21'(b[5:0]);
          seq_bytes = '0;
          seq_len = 0;
          push_result(cp, 1'b1, bin_of(cp), 3'(need));
        end
      end
      if (it.last_of_word && seq_len != 0) flush_seq();
    end else if (it.cmd == CMD_READ) begin
      expected_q.push_back('{code_point: 21'd0, is_valid: 1'b0, block_index: it.counter_index,
                             byte_count: 3'd0, last_result: 1'b0,
                             count_value: it.counter_index < NBINS ?
                                          hist[it.counter_index] : 32'd0});
    end else if (it.cmd == CMD_CLEAR) begin
      foreach (hist[i]) hist[i] = '0;
    end
    if (expected_q.size() > n_prior) expected_q[$].last_result = 1'b1;
  endtask

  task automatic report(input string what, input char_result_t got, input char_result_t exp);
    n_fail++;
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, exp);
  endtask

  // Offer one item with a random gap before it
  task automatic send_item(input byte_item_t it, input bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                    ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= it.cmd;
    in_ch.data_byte     <= it.data_byte;
    in_ch.last_of_word  <= it.last_of_word;
    in_ch.counter_index <= it.counter_index;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(it);
    n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lw = 1'b0);
    send_item('{cmd: CMD_DATA, data_byte: b, last_of_word: lw, counter_index: 8'd0});
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_item('{cmd: CMD_READ, data_byte: 8'($urandom), last_of_word: 1'($urandom),
                counter_index: idx});
  endtask

  task automatic end_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    char_result_t got, exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{code_point: out_ch.code_point, is_valid: out_ch.is_valid,
              block_index: out_ch.block_index, byte_count: out_ch.byte_count,
              count_value: out_ch.count_value, last_result: out_ch.last_result};
      if (expected_q.size() == 0) report("unexpected result", got, got);
      else begin
        exp = expected_q.pop_front();
        if (got.code_point != exp.code_point) report("code_point", got, exp);
        if (got.is_valid != exp.is_valid) report("is_valid", got, exp);
        if (got.block_index != exp.block_index) report("block_index", got, exp);
        if (got.byte_count != exp.byte_count) report("byte_count", got, exp);
        if (got.count_value != exp.count_value) report("count_value", got, exp);
        if (got.last_result != exp.last_result) report("last_result", got, exp);
      end
    end
  end

  // Receiver stalls: random, or a long hold-off when asked
  always @(posedge clk_i) begin
    int hold;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall.hold_off) begin
      hold = 200;
      out_ch.ready <= 1'b0;
      while (hold > 0) begin
        @(posedge clk_i);
        hold--;
      end
      stall.hold_off = 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic test_ascii_and_controls();
    send_byte(8'h00);
    send_byte(8'h1f);
    send_byte(8'h20);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_multibyte_edges();
    send_byte(8'hc2); send_byte(8'h80);
    send_byte(8'hdf); send_byte(8'hbf);
    send_byte(8'he0); send_byte(8'ha0); send_byte(8'h80);
    send_byte(8'hed); send_byte(8'hbf); send_byte(8'hbf);
    send_byte(8'hf0); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hf4); send_byte(8'h8f); send_byte(8'hbf); send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_broken_forms();
    // bad leads, overlong, above range, cut short by the word end
    send_byte(8'hc0); send_byte(8'hc1); send_byte(8'hf5); send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'he0); send_byte(8'h9f);
    send_byte(8'hf0); send_byte(8'h8f);
    send_byte(8'hf4); send_byte(8'h90);
    send_byte(8'hf1); send_byte(8'h80); send_byte(8'h80); send_byte(8'h41);
    send_byte(8'he2); send_byte(8'h82, 1'b1);
  endtask

  task automatic test_commands();
    // reads and clears leave an open sequence alone; command 3 does nothing
    send_byte(8'he2);
    send_read(8'd0);
    send_read(8'd2);
    send_read(8'd165);
    send_read(8'd166);
    send_read(8'd255);
    send_item('{cmd: 2'd3, data_byte: 8'hff, last_of_word: 1'b1, counter_index: 8'hff});
    send_item('{cmd: CMD_CLEAR, data_byte: 8'h00, last_of_word: 1'b1, counter_index: 8'd0});
    send_byte(8'h82); send_byte(8'hac);
    send_read(8'd75);
    send_read(8'd2);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Random well-formed characters, mixed with noise and commands
  task automatic test_random_stream(input int n_items, input bit gaps);
    int k, kind;
    logic [20:0] cp;
    k = 0;
    while (k < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        case ($urandom_range(0, 3))
          0: cp = 21'($urandom_range(0, 8'h7f));
          1: cp = 21'($urandom_range(12'h080, 12'h7ff));
          2: cp = 21'($urandom_range(16'h0800, 16'hffff));
          default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
        endcase
        if (cp < 21'h80) begin
          send_item('{cmd: CMD_DATA, data_byte: 8'(cp), last_of_word: 1'($urandom),
                      counter_index: 8'($urandom)}, gaps);
          k++;
        end else if (cp < 21'h800) begin
          send_item('{CMD_DATA, 8'hc0 | 8'(cp >> 6), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[5:0]), 1'($urandom), 8'($urandom)}, gaps);
          k += 2;
        end else if (cp < 21'h10000) begin
          send_item('{CMD_DATA, 8'he0 | 8'(cp >> 12), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[11:6]), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[5:0]), 1'($urandom), 8'($urandom)}, gaps);
          k += 3;
        end else begin
          send_item('{CMD_DATA, 8'hf0 | 8'(cp >> 18), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[17:12]), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[11:6]), 1'b0, 8'($urandom)}, gaps);
          send_item('{CMD_DATA, 8'h80 | 8'(cp[5:0]), 1'($urandom), 8'($urandom)}, gaps);
          k += 4;
        end
      end else if (kind < 16) begin
        send_item('{CMD_DATA, 8'($urandom), 1'($urandom), 8'($urandom)}, gaps);
        k++;
      end else if (kind < 17) begin
        // short sequence: a lead byte then a single continuation byte
        send_item('{CMD_DATA, 8'($urandom_range(8'hc2, 8'hf4)), 1'b0, 8'($urandom)}, gaps);
        send_item('{CMD_DATA, cont_byte(), 1'($urandom), 8'($urandom)}, gaps);
        k += 2;
      end else if (kind < 19) begin
        send_item('{CMD_READ, 8'($urandom), 1'($urandom),
                    8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 165))}, gaps);
        k++;
      end else begin
        send_item('{cmd: $urandom_range(0, 1) ? CMD_CLEAR : 2'd3, data_byte: 8'($urandom),
                    last_of_word: 1'($urandom), counter_index: 8'($urandom)}, gaps);
        k++;
      end
    end
  endtask

  task automatic test_backpressure();
    stall.hold_off = 1'b1;
    test_random_stream(24, 1'b0);
    wait_drained();
  endtask

  initial begin
    n_fail = 0; n_sent = 0; n_chars = 0; n_bad = 0;
    seq_bytes = '0; seq_len = 0;
    foreach (hist[i]) hist[i] = '0;
    stall.hold_off = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_DATA;
    in_ch.data_byte <= 8'd0;
    in_ch.last_of_word <= 1'b0;
    in_ch.counter_index <= 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii_and_controls();
    test_multibyte_edges();
    test_broken_forms();
    wait_drained();
    test_commands();
    wait_drained();
    test_random_stream(20, 1'b1);
    wait_drained();
    test_backpressure();
    // close any open sequence and dump a few counters
    send_byte(8'h0a, 1'b1);
    for (int i = 0; i < 4; i++) send_read(8'($urandom_range(0, 165)));
    wait_drained();

    $display("Covered %0d items: %0d characters, %0d invalid bytes, reads and clears,",
             n_sent, n_chars, n_bad);
    $display("with random gaps on both sides and a long receiver hold-off.");
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
